@@ hdl/iupx_pkg.sv @@
package iupx_pkg;

  // field widths of the channels and registers
  localparam int unsigned SW_W       = 9;
  localparam int unsigned SH_W       = 8;
  localparam int unsigned OX_W       = 9;
  localparam int unsigned OY_W       = 8;
  localparam int unsigned SF_W       = 8;
  localparam int unsigned PIX_W      = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 9;

  // default panel size
  localparam int unsigned PANEL_WIDTH_DEF  = 320;
  localparam int unsigned PANEL_HEIGHT_DEF = 240;

  // result queue between the front and back parts
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QLVL_W      = $clog2(QUEUE_DEPTH + 1);

  // register indexes on the configuration channel
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH  = 3'd0,
    REG_SRC_HEIGHT = 3'd1,
    REG_ORIGIN_X   = 3'd2,
    REG_ORIGIN_Y   = 3'd3,
    REG_SCALE      = 3'd4
  } cfg_reg_e;

  // result kinds
  typedef enum logic [2:0] {
    KIND_IDLE     = 3'd0,
    KIND_WINDOW   = 3'd1,
    KIND_PIXEL    = 3'd2,
    KIND_ACCEPTED = 3'd3,
    KIND_REFUSED  = 3'd4
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [OX_W-1:0]   win_x_start;
    logic [OX_W-1:0]   win_x_end;
    logic [OY_W-1:0]   win_row;
    logic [PIX_W-1:0]  pixel_out;
    logic              row_end;
    logic              frame_end;
  } result_t;

  // one result handed from the front to the queue
  typedef struct packed {
    logic    valid;
    result_t res;
  } push_t;

endpackage

@@ hdl/iupx_ifs.sv @@
interface iupx_in_if;
  logic                        valid;
  logic                        ready;
  logic                        func;
  logic [iupx_pkg::PIX_W-1:0]  pixel_in;

  modport source (output valid, func, pixel_in, input ready);
  modport sink   (input valid, func, pixel_in, output ready);
endinterface

interface iupx_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [iupx_pkg::CFG_IDX_W-1:0]   index;
  logic [iupx_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

interface iupx_out_if;
  logic                        valid;
  logic                        ready;
  iupx_pkg::kind_e             kind;
  logic [iupx_pkg::OX_W-1:0]   win_x_start;
  logic [iupx_pkg::OX_W-1:0]   win_x_end;
  logic [iupx_pkg::OY_W-1:0]   win_row;
  logic [iupx_pkg::PIX_W-1:0]  pixel_out;
  logic                        row_end;
  logic                        frame_end;

  modport source (output valid, kind, win_x_start, win_x_end, win_row, pixel_out,
                  row_end, frame_end, input ready);
  modport sink   (input valid, kind, win_x_start, win_x_end, win_row, pixel_out,
                  row_end, frame_end, output ready);
endinterface

@@ hdl/iupx_front.sv @@
module iupx_front #(
  parameter int unsigned PANEL_WIDTH  = iupx_pkg::PANEL_WIDTH_DEF,
  parameter int unsigned PANEL_HEIGHT = iupx_pkg::PANEL_HEIGHT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  iupx_in_if.sink                       in_i,
  iupx_cfg_if.sink                      cfg_i,
  input  logic [iupx_pkg::QLVL_W-1:0]   level_i,
  output iupx_pkg::push_t               push_o
);
  import iupx_pkg::*;

  localparam int unsigned ADDR_W = $clog2(PANEL_WIDTH);
  localparam int unsigned ROW_W  = $clog2(PANEL_HEIGHT);
  localparam int unsigned SCW_W  = SW_W + SF_W;
  localparam int unsigned SCH_W  = SH_W + SF_W;

  // configuration registers
  logic [SW_W-1:0] sw_q, sw_d;
  logic [SH_W-1:0] sh_q, sh_d;
  logic [OX_W-1:0] ox_q, ox_d;
  logic [OY_W-1:0] oy_q, oy_d;
  logic [SF_W-1:0] sf_q, sf_d;

  // frame state
  logic [SW_W-1:0]  fill_col_q, fill_col_d;
  logic [SH_W-1:0]  src_row_q, src_row_d;
  logic             draining_q, draining_d;
  logic             win_sent_q, win_sent_d;
  logic [SF_W-1:0]  rep_row_q, rep_row_d;
  logic [SW_W-1:0]  read_col_q, read_col_d;
  logic [SF_W-1:0]  rep_col_q, rep_col_d;
  logic [ROW_W-1:0] row_off_q, row_off_d;

  // result stage
  logic             s1_valid_q;
  result_t          s1_res_q, s1_res_d;
  logic             s1_pix_q;

  // row store
  logic [PIX_W-1:0] store_q [PANEL_WIDTH];
  logic [PIX_W-1:0] rd_q;
  logic             wr_en, rd_en;

  logic             in_fire, cfg_fire, restart;
  logic [SCW_W-1:0] scaled_w;
  logic [SCH_W-1:0] scaled_h;
  logic [SCW_W:0]   x_span;
  logic [SCH_W:0]   y_span;
  logic             geo_ok;
  logic             col_last, row_last, rep_last, frame_last;

  // geometry check at full precision
  assign scaled_w = {{SF_W{1'b0}}, sw_q} * {{SW_W{1'b0}}, sf_q};
  assign scaled_h = {{SF_W{1'b0}}, sh_q} * {{SH_W{1'b0}}, sf_q};
  assign x_span   = {1'b0, scaled_w} + (SCW_W+1)'(ox_q);
  assign y_span   = {1'b0, scaled_h} + (SCH_W+1)'(oy_q);
  assign geo_ok   = (sf_q != '0) && (sw_q != '0) && (sh_q != '0) &&
                    (x_span <= (SCW_W+1)'(PANEL_WIDTH)) &&
                    (y_span <= (SCH_W+1)'(PANEL_HEIGHT));

  // room in the queue counts the result still in flight,
  // input waits while a register write is offered
  assign in_i.ready = !cfg_i.valid &&
                      ((level_i + QLVL_W'(s1_valid_q)) < QLVL_W'(QUEUE_DEPTH));
  assign cfg_i.ready = 1'b1;
  assign in_fire  = in_i.valid && in_i.ready;
  assign cfg_fire = cfg_i.valid && cfg_i.ready;

  // end of replication counters
  assign col_last   = ({1'b0, rep_col_q} + 9'd1) >= {1'b0, sf_q};
  assign row_last   = col_last && (({1'b0, read_col_q} + 10'd1) >= {1'b0, sw_q});
  assign rep_last   = ({1'b0, rep_row_q} + 9'd1) >= {1'b0, sf_q};
  assign frame_last = ({1'b0, src_row_q} + 9'd1) >= {1'b0, sh_q};

  // classification and state update
  always_comb begin
    sw_d        = sw_q;
    sh_d        = sh_q;
    ox_d        = ox_q;
    oy_d        = oy_q;
    sf_d        = sf_q;
    fill_col_d  = fill_col_q;
    src_row_d   = src_row_q;
    draining_d  = draining_q;
    win_sent_d  = win_sent_q;
    rep_row_d   = rep_row_q;
    read_col_d  = read_col_q;
    rep_col_d   = rep_col_q;
    row_off_d   = row_off_q;
    s1_res_d    = '0;
    s1_res_d.kind = KIND_IDLE;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    restart     = 1'b0;

    if (cfg_fire) begin
      unique case (cfg_i.index)
        REG_SRC_WIDTH: begin
          sw_d    = cfg_i.data;
          restart = 1'b1;
        end
        REG_SRC_HEIGHT: begin
          sh_d    = cfg_i.data[SH_W-1:0];
          restart = 1'b1;
        end
        REG_ORIGIN_X: begin
          ox_d    = cfg_i.data;
          restart = 1'b1;
        end
        REG_ORIGIN_Y: begin
          oy_d    = cfg_i.data[OY_W-1:0];
          restart = 1'b1;
        end
        REG_SCALE: begin
          sf_d    = cfg_i.data[SF_W-1:0];
          restart = 1'b1;
        end
        default: restart = 1'b0;
      endcase
    end else if (in_fire) begin
      if (!in_i.func) begin
        // source pixel into the row store
        if (!geo_ok || draining_q) begin
          s1_res_d.kind = KIND_REFUSED;
        end else begin
          wr_en         = 1'b1;
          s1_res_d.kind = KIND_ACCEPTED;
          if (({1'b0, fill_col_q} + 10'd1) >= {1'b0, sw_q}) begin
            fill_col_d = '0;
            draining_d = 1'b1;
            win_sent_d = 1'b0;
            rep_row_d  = '0;
            read_col_d = '0;
            rep_col_d  = '0;
          end else begin
            fill_col_d = fill_col_q + 1'b1;
          end
        end
      end else if (geo_ok && draining_q) begin
        if (!win_sent_q) begin
          // window of the next output row
          s1_res_d.kind        = KIND_WINDOW;
          s1_res_d.win_x_start = ox_q;
          s1_res_d.win_x_end   = OX_W'(x_span - 1'b1);
          s1_res_d.win_row     = oy_q + OY_W'(row_off_q);
          win_sent_d           = 1'b1;
        end else begin
          // replicated pixel out of the store
          s1_res_d.kind = KIND_PIXEL;
          rd_en         = 1'b1;
          if (col_last) begin
            rep_col_d  = '0;
            read_col_d = read_col_q + 1'b1;
          end else begin
            rep_col_d  = rep_col_q + 1'b1;
          end
          if (row_last) begin
            s1_res_d.row_end = 1'b1;
            read_col_d = '0;
            rep_col_d  = '0;
            win_sent_d = 1'b0;
            row_off_d  = row_off_q + 1'b1;
            if (rep_last) begin
              rep_row_d  = '0;
              draining_d = 1'b0;
              if (frame_last) begin
                src_row_d          = '0;
                row_off_d          = '0;
                s1_res_d.frame_end = 1'b1;
              end else begin
                src_row_d = src_row_q + 1'b1;
              end
            end else begin
              rep_row_d = rep_row_q + 1'b1;
            end
          end
        end
      end
    end

    // a write to one of the five registers starts a new frame
    if (restart) begin
      fill_col_d = '0;
      src_row_d  = '0;
      draining_d = 1'b0;
      win_sent_d = 1'b0;
      rep_row_d  = '0;
      read_col_d = '0;
      rep_col_d  = '0;
      row_off_d  = '0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q       <= SW_W'(1);
      sh_q       <= SH_W'(1);
      ox_q       <= '0;
      oy_q       <= '0;
      sf_q       <= SF_W'(1);
      fill_col_q <= '0;
      src_row_q  <= '0;
      draining_q <= 1'b0;
      win_sent_q <= 1'b0;
      rep_row_q  <= '0;
      read_col_q <= '0;
      rep_col_q  <= '0;
      row_off_q  <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      sw_q       <= sw_d;
      sh_q       <= sh_d;
      ox_q       <= ox_d;
      oy_q       <= oy_d;
      sf_q       <= sf_d;
      fill_col_q <= fill_col_d;
      src_row_q  <= src_row_d;
      draining_q <= draining_d;
      win_sent_q <= win_sent_d;
      rep_row_q  <= rep_row_d;
      read_col_q <= read_col_d;
      rep_col_q  <= rep_col_d;
      row_off_q  <= row_off_d;
      s1_valid_q <= in_fire && !cfg_fire;
    end
  end

  // row store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[ADDR_W'(fill_col_q)] <= in_i.pixel_in;
    end
    if (rd_en) begin
      rd_q <= store_q[ADDR_W'(read_col_q)];
    end
  end

  // result stage payload
  always_ff @(posedge clk_i) begin
    s1_res_q <= s1_res_d;
    s1_pix_q <= rd_en;
  end

  // hand the result to the queue with the store data merged in
  always_comb begin
    push_o.valid = s1_valid_q;
    push_o.res   = s1_res_q;
    push_o.res.pixel_out = s1_pix_q ? rd_q : '0;
  end

endmodule

@@ hdl/iupx_queue.sv @@
module iupx_queue (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  iupx_pkg::push_t               push_i,
  output logic [iupx_pkg::QLVL_W-1:0]   level_o,
  iupx_out_if.source                    out_o
);
  import iupx_pkg::*;

  result_t           slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QLVL_W-1:0] count_q;
  logic              pop;
  result_t           head;

  assign pop     = out_o.valid && out_o.ready;
  assign level_o = count_q;
  assign head    = slot_q[rd_ptr_q];

  // head entry drives the output channel
  assign out_o.valid       = count_q != '0;
  assign out_o.kind        = head.kind;
  assign out_o.win_x_start = head.win_x_start;
  assign out_o.win_x_end   = head.win_x_end;
  assign out_o.win_row     = head.win_row;
  assign out_o.pixel_out   = head.pixel_out;
  assign out_o.row_end     = head.row_end;
  assign out_o.frame_end   = head.frame_end;

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i.valid) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      count_q <= count_q + QLVL_W'(push_i.valid) - QLVL_W'(pop);
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      slot_q[wr_ptr_q] <= push_i.res;
    end
  end

endmodule

@@ hdl/integer_pixel_upscaler.sv @@
// Nearest-neighbour integer upscaler for a small display panel.
// in_i carries transactions of two sorts: func low brings one RGB565 source
// pixel in raster order, func high is a tick asking for the next output item.
// Every input transaction gives exactly one result on out_o: pixel accepted or
// refused, idle, a row window (x start, x end, panel row) or one replicated
// pixel with row and frame end flags.
// cfg_i writes the five geometry registers (width, height, origin x, origin y,
// scale); a write to one of them restarts the frame. Write only while the
// block is idle; in_i.ready is held low while a register write is offered.
// Throughput is one transaction per cycle while in_i.ready is high: the row
// store has one write port for incoming pixels and one registered read port
// for outgoing pixels. The result of an accepted input transaction passes
// through the result register, then the result queue, before it can be
// taken on out_o.
// When out_o stalls, the four-entry result queue absorbs work in flight and
// in_i.ready drops once the queue and the result register together hold four.
// Reset restores width 1, height 1, origin 0,0, scale 1 and an empty frame;
// the row store is not cleared and needs no clearing pass.
module integer_pixel_upscaler #(
  parameter int unsigned PANEL_WIDTH  = iupx_pkg::PANEL_WIDTH_DEF,
  parameter int unsigned PANEL_HEIGHT = iupx_pkg::PANEL_HEIGHT_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  iupx_in_if.sink    in_i,
  iupx_cfg_if.sink   cfg_i,
  iupx_out_if.source out_o
);
  import iupx_pkg::*;

  push_t             push;
  logic [QLVL_W-1:0] level;

  // front: classification, frame state and row store
  iupx_front #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .cfg_i   (cfg_i),
    .level_i (level),
    .push_o  (push)
  );

  // back: result queue feeding the output channel
  iupx_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .level_o (level),
    .out_o   (out_o)
  );

  // queue never takes a result when full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.valid |-> level < QLVL_W'(QUEUE_DEPTH))
    else $error("result queue overflow");

  // every accepted input transaction reaches the queue next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && !(cfg_i.valid && cfg_i.ready)) |=> push.valid)
    else $error("accepted transaction lost");

  // frame end only on the last pixel of a row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.frame_end) |-> (out_o.row_end && out_o.kind == KIND_PIXEL))
    else $error("frame end outside a row end pixel");

endmodule

@@ sim/tb_integer_pixel_upscaler.sv @@
`timescale 1ns / 1ps

module tb_integer_pixel_upscaler;
  import iupx_pkg::*;

  localparam int unsigned PANEL_W     = PANEL_WIDTH_DEF;
  localparam int unsigned PANEL_H     = PANEL_HEIGHT_DEF;
  localparam int unsigned ITEM_TARGET = 1450;
  localparam int unsigned HANG_LIMIT  = 3000;
  localparam int unsigned MAX_REPORTS = 10;

  // indexes past the end of the register list, writes there are ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic             func;
    logic [PIX_W-1:0] pix;
  } src_item_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  iupx_in_if  in_if ();
  iupx_cfg_if cfg_if ();
  iupx_out_if out_if ();

  integer_pixel_upscaler u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  always #5 clk_i = ~clk_i;

  // pending source transactions and predicted upscaler output stream
  src_item_t   source_stream_q[$];
  result_t     scaled_stream_q[$];
  int unsigned issued       = 0;
  int unsigned taken        = 0;
  int unsigned fed_items    = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned stall_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  // geometry registers as the block should hold them
  int unsigned src_w = 1;
  int unsigned src_h = 1;
  int unsigned org_x = 0;
  int unsigned org_y = 0;
  int unsigned zoom  = 1;

  // row store and frame walk state
  logic [PIX_W-1:0] line_mem [0:PANEL_W-1];
  int unsigned fill_pos    = 0;
  int unsigned image_row   = 0;
  bit          draining    = 1'b0;
  bit          window_done = 1'b0;
  int unsigned row_rep     = 0;
  int unsigned read_pos    = 0;
  int unsigned col_rep     = 0;
  int unsigned out_pos     = 0;

  function automatic bit geometry_fits();
    if (zoom == 0 || src_w == 0 || src_h == 0) return 1'b0;
    if (org_x + src_w * zoom > PANEL_W) return 1'b0;
    if (org_y + src_h * zoom > PANEL_H) return 1'b0;
    return 1'b1;
  endfunction

  // register write, any known index restarts the frame
  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    case (idx)
      REG_SRC_WIDTH:  src_w = 32'(d[SW_W-1:0]);
      REG_SRC_HEIGHT: src_h = 32'(d[SH_W-1:0]);
      REG_ORIGIN_X:   org_x = 32'(d[OX_W-1:0]);
      REG_ORIGIN_Y:   org_y = 32'(d[OY_W-1:0]);
      REG_SCALE:      zoom  = 32'(d[SF_W-1:0]);
      default:        return;
    endcase
    fill_pos    = 0;
    image_row   = 0;
    draining    = 1'b0;
    window_done = 1'b0;
    row_rep     = 0;
    read_pos    = 0;
    col_rep     = 0;
    out_pos     = 0;
  endfunction

  // next output of the upscaler for one source transaction
  function automatic result_t upscale_step(logic func, logic [PIX_W-1:0] pix);
    result_t     r;
    bit          ok;
    int unsigned span;
    r    = '0;
    ok   = geometry_fits();
    span = src_w * zoom;
    if (!func) begin
      if (!ok || draining || fill_pos >= PANEL_W) begin
        r.kind = KIND_REFUSED;
      end else begin
        line_mem[fill_pos] = pix;
        fill_pos++;
        if (fill_pos >= src_w) begin
          fill_pos    = 0;
          draining    = 1'b1;
          window_done = 1'b0;
          row_rep     = 0;
          read_pos    = 0;
          col_rep     = 0;
          out_pos     = 0;
        end
        r.kind = KIND_ACCEPTED;
      end
    end else if (ok && draining) begin
      if (!window_done) begin
        r.kind        = KIND_WINDOW;
        r.win_x_start = OX_W'(org_x);
        r.win_x_end   = OX_W'(org_x + span - 1);
        r.win_row     = OY_W'(org_y + image_row * zoom + row_rep);
        window_done   = 1'b1;
      end else begin
        r.kind      = KIND_PIXEL;
        r.pixel_out = (read_pos < PANEL_W) ? line_mem[read_pos] : '0;
        col_rep++;
        if (col_rep >= zoom) begin
          col_rep = 0;
          read_pos++;
        end
        out_pos++;
        if (out_pos >= span) begin
          r.row_end   = 1'b1;
          out_pos     = 0;
          read_pos    = 0;
          col_rep     = 0;
          window_done = 1'b0;
          row_rep++;
          if (row_rep >= zoom) begin
            row_rep  = 0;
            draining = 1'b0;
            image_row++;
            if (image_row >= src_h) begin
              image_row   = 0;
              r.frame_end = 1'b1;
            end
          end
        end
      end
    end
    return r;
  endfunction

  function automatic string fmt_result(result_t r);
    return $sformatf("kind %0d xs %0d xe %0d row %0d pix %04h re %0b fe %0b", r.kind,
                     r.win_x_start, r.win_x_end, r.win_row, r.pixel_out, r.row_end,
                     r.frame_end);
  endfunction

  // source driver, predicts on every accepted transaction
  always @(posedge clk_i or negedge rst_ni) begin
    src_item_t next_src;
    if (!rst_ni) begin
      in_if.valid    <= 1'b0;
      in_if.func     <= 1'b0;
      in_if.pixel_in <= '0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        scaled_stream_q.push_back(upscale_step(in_if.func, in_if.pixel_in));
        taken++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (source_stream_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_src = source_stream_q.pop_front();
          in_if.valid    <= 1'b1;
          in_if.func     <= next_src.func;
          in_if.pixel_in <= next_src.pix;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got.kind        = out_if.kind;
        got.win_x_start = out_if.win_x_start;
        got.win_x_end   = out_if.win_x_end;
        got.win_row     = out_if.win_row;
        got.pixel_out   = out_if.pixel_out;
        got.row_end     = out_if.row_end;
        got.frame_end   = out_if.frame_end;
        if (scaled_stream_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("%0t: unexpected result: %s", $realtime, fmt_result(got));
        end else begin
          want = scaled_stream_q.pop_front();
          if (got.kind !== want.kind || got.win_x_start !== want.win_x_start ||
              got.win_x_end !== want.win_x_end || got.win_row !== want.win_row ||
              got.pixel_out !== want.pixel_out || got.row_end !== want.row_end ||
              got.frame_end !== want.frame_end) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORTS) begin
              $display("%0t: mismatch", $realtime);
              $display("  expected %s", fmt_result(want));
              $display("  actual   %s", fmt_result(got));
            end
          end
        end
      end
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // hang detection: cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin
    while (stall_cycles < HANG_LIMIT) @(posedge clk_i);
    $display("integer_pixel_upscaler verification failed");
    $finish;
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!(cfg_if.valid && cfg_if.ready));
    apply_reg(idx, value);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_geometry(input int unsigned w, input int unsigned h,
                              input int unsigned ox, input int unsigned oy,
                              input int unsigned s);
    write_reg(REG_SRC_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_SRC_HEIGHT, CFG_DATA_W'(h));
    write_reg(REG_ORIGIN_X, CFG_DATA_W'(ox));
    write_reg(REG_ORIGIN_Y, CFG_DATA_W'(oy));
    write_reg(REG_SCALE, CFG_DATA_W'(s));
  endtask

  task automatic push_src(input logic func, input logic [PIX_W-1:0] pix, input bit counted);
    src_item_t it;
    it.func = func;
    it.pix  = pix;
    source_stream_q.push_back(it);
    issued++;
    if (counted) fed_items++;
  endtask

  // drain everything, pause, then move to the next idling pattern
  task automatic next_phase(input int unsigned phase_no);
    while (taken != issued || scaled_stream_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    case (phase_no % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
      default: begin send_idle_pct = 31; recv_stall_pct = 31; end
    endcase
  endtask

  // well-formed frames with random pixels, stray ticks and stray pixels mixed in
  task automatic gen_frames(input int unsigned frames, input int unsigned budget);
    int unsigned made;
    made = 0;
    for (int unsigned f = 0; f < frames; f++) begin
      for (int unsigned r = 0; r < src_h; r++) begin
        for (int unsigned c = 0; c < src_w; c++) begin
          if ($urandom_range(9) == 0) push_src(1'b1, PIX_W'($urandom), 1'b0);
          push_src(1'b0, PIX_W'($urandom), 1'b1);
          made++;
          if (made >= budget || fed_items >= ITEM_TARGET) return;
        end
        for (int unsigned k = 0; k < zoom * (1 + src_w * zoom); k++) begin
          if ($urandom_range(9) == 0) push_src(1'b0, PIX_W'($urandom), 1'b0);
          push_src(1'b1, PIX_W'($urandom), 1'b1);
          made++;
          if (made >= budget || fed_items >= ITEM_TARGET) return;
        end
      end
    end
  endtask

  initial begin
    int unsigned phase_no;
    int unsigned rnd_phase;
    int unsigned pick;
    int unsigned s;
    int unsigned w;
    int unsigned h;
    phase_no        = 0;
    rnd_phase       = 0;
    rst_ni          = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = REG_SRC_WIDTH;
    cfg_if.data     = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset geometry: tick while filling, refused pixel while draining
    push_src(1'b1, 16'h0000, 1'b0);
    push_src(1'b0, 16'hFFFF, 1'b1);
    push_src(1'b0, 16'h0000, 1'b0);
    push_src(1'b1, 16'hFFFF, 1'b1);
    push_src(1'b1, 16'h0000, 1'b1);
    push_src(1'b0, 16'h0000, 1'b1);
    push_src(1'b1, 16'h0000, 1'b1);
    push_src(1'b1, 16'hFFFF, 1'b1);

    // zero scale refuses pixels and answers ticks with idle
    next_phase(++phase_no);
    write_reg(REG_SCALE, '0);
    push_src(1'b0, 16'h5A5A, 1'b0);
    push_src(1'b1, 16'hA5A5, 1'b0);

    // image flush against the bottom right corner, left with half a row
    next_phase(++phase_no);
    set_geometry(2, 2, PANEL_W - 2, PANEL_H - 2, 1);
    push_src(1'b0, 16'h1234, 1'b1);
    push_src(1'b0, 16'hFEDC, 1'b1);
    push_src(1'b1, 16'h0F0F, 1'b1);
    push_src(1'b1, 16'hF0F0, 1'b1);
    push_src(1'b1, 16'h0000, 1'b1);
    push_src(1'b0, 16'hAAAA, 1'b1);

    // writes past the register list must not restart the frame
    next_phase(++phase_no);
    for (int unsigned i = REG_SPARE_LO; i <= REG_SPARE_HI; i++)
      write_reg(CFG_IDX_W'(i), CFG_DATA_W'($urandom));
    push_src(1'b0, 16'h5555, 1'b1);
    push_src(1'b1, 16'h0000, 1'b1);
    push_src(1'b1, 16'h0000, 1'b1);
    push_src(1'b1, 16'h0000, 1'b1);

    // one column past the right edge
    next_phase(++phase_no);
    set_geometry(2, 1, PANEL_W - 1, 0, 1);
    push_src(1'b0, 16'h8001, 1'b0);
    push_src(1'b1, 16'h7FFE, 1'b0);

    fed_items = 0;
    while (fed_items < ITEM_TARGET) begin
      next_phase(++phase_no);
      rnd_phase++;
      pick = $urandom_range(19);
      if (rnd_phase == 2) begin
        // full panel width
        set_geometry(PANEL_W, 1, 0, 0, 1);
        gen_frames(1, 1000);
      end else if (rnd_phase == 4) begin
        // largest usable scale, cut off part-way through the drain
        set_geometry(1, 1, $urandom_range(0, PANEL_W - PANEL_H), 0, PANEL_H);
        gen_frames(1, 300);
      end else if (pick < 2) begin
        // arbitrary register contents, mostly outside the panel
        write_reg(REG_SRC_WIDTH, CFG_DATA_W'($urandom));
        write_reg(REG_SRC_HEIGHT, CFG_DATA_W'($urandom));
        write_reg(REG_ORIGIN_X, CFG_DATA_W'($urandom));
        write_reg(REG_ORIGIN_Y, CFG_DATA_W'($urandom));
        write_reg(REG_SCALE, CFG_DATA_W'($urandom));
        repeat (16) push_src(1'($urandom), PIX_W'($urandom), 1'b0);
      end else if (pick < 4) begin
        // scaled image exactly fills the panel, partial frame
        set_geometry(20, 15, 0, 0, 16);
        gen_frames(1, $urandom_range(40, 200));
      end else begin
        s = $urandom_range(1, 4);
        w = $urandom_range(1, 8);
        h = $urandom_range(1, 3);
        set_geometry(w, h, $urandom_range(0, PANEL_W - w * s),
                     $urandom_range(0, PANEL_H - h * s), s);
        if ($urandom_range(3) == 0)
          gen_frames(1, $urandom_range(5, 60));
        else
          gen_frames($urandom_range(1, 2), 100000);
      end
    end

    while (taken != issued || scaled_stream_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatch_cnt == 0 && scaled_stream_q.size() == 0)
      $display("integer_pixel_upscaler verification clean");
    else
      $display("integer_pixel_upscaler verification failed");
    $finish;
  end

endmodule
